// ===== src/vle_pkg.sv =====
// ----------------------------------------------------------------------------
// vle_pkg: shared types for the visible lines upper envelope unit
// Field widths, the stacked line record and the cross test operand width.
// ----------------------------------------------------------------------------
package vle_pkg;

	localparam int FIELD_W = 16;   // slope / intercept width
	localparam int IDX_W   = 6;    // input order index width
	localparam int OPND_W  = FIELD_W + 1;   // difference of two fields
	localparam int PROD_W  = 2 * OPND_W;    // one cross product
	localparam int SUM_W   = PROD_W + 1;    // sum of two cross products

	// one stacked line
	typedef struct packed {
		logic signed [FIELD_W-1:0] slope;
		logic signed [FIELD_W-1:0] intercept;
		logic        [IDX_W-1:0]   index;
	} line_t;

	// control word for the shared cross multiplier
	typedef struct packed {
		logic load;   // 1: start a new test, 0: add second product
	} cross_ctl_t;

endpackage

// ===== src/vle_stack_mem.sv =====
// ----------------------------------------------------------------------------
// vle_stack_mem: line stack storage
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module vle_stack_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  vle_pkg::line_t        wdata,
	input  logic                  re_a,
	input  logic [ADDR_W-1:0]     raddr_a,
	input  logic                  re_b,
	input  logic [ADDR_W-1:0]     raddr_b,
	output vle_pkg::line_t        rdata_a,
	output vle_pkg::line_t        rdata_b
);

	vle_pkg::line_t mem_q [DEPTH];
	vle_pkg::line_t rd_a_q;
	vle_pkg::line_t rd_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (re_a) begin
			rd_a_q <= mem_q[raddr_a];
		end
		if (re_b) begin
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== src/vle_cross_unit.sv =====
// ----------------------------------------------------------------------------
// vle_cross_unit: shared multiply-accumulate for the hidden line test
// First pass stores a*b, second pass adds a*b and flags a positive sum.
// ----------------------------------------------------------------------------
module vle_cross_unit (
	input  logic                                 clk,
	input  vle_pkg::cross_ctl_t                  ctl,
	input  logic signed [vle_pkg::OPND_W-1:0]    opa,
	input  logic signed [vle_pkg::OPND_W-1:0]    opb,
	output logic                                 hidden
);

	logic signed [vle_pkg::PROD_W-1:0] prod;
	logic signed [vle_pkg::PROD_W-1:0] acc_q;
	logic signed [vle_pkg::SUM_W-1:0]  sum;

	// single shared multiplier
	assign prod = opa * opb;

	// first product held for the second pass
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= prod;
		end
	end

	assign sum    = {acc_q[vle_pkg::PROD_W-1], acc_q} + {prod[vle_pkg::PROD_W-1], prod};
	assign hidden = !sum[vle_pkg::SUM_W-1] && (sum != '0);

endmodule

// ===== src/visible_lines_upper_envelope_unit.sv =====
// ----------------------------------------------------------------------------
// visible_lines_upper_envelope_unit: upper envelope of a set of lines
// Stack based visible line search with one shared cross multiplier.
// ----------------------------------------------------------------------------
// Lines y = slope*x + intercept arrive one word each, in increasing slope
// order; last_line closes the set. A line that needs no scan (the first two
// of a set, or one dropped past MAX_LINES) is taken without any scan. Every later
// line is pushed and then tested against stacked position pairs (p, q),
// p from 1 below the new top, q below p; each pair passes through three
// steps of the shared multiplier (read both entries, first product, second
// product and compare), at most k*(k-1)/2 pairs for a stack of depth k, and
// the scan stops at the first hidden position. On the closing line the
// indices of the visible lines go out in ascending order, one word at a time
// (read, then offered until out_ready), overflow set on each word when lines
// were dropped; the unit then clears for the next set. in_ready is low while
// a scan or the result list is in progress.
// ----------------------------------------------------------------------------
module visible_lines_upper_envelope_unit #(
	parameter int MAX_LINES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [vle_pkg::FIELD_W-1:0] slope,
	input  logic signed [vle_pkg::FIELD_W-1:0] intercept,
	input  logic                               last_line,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic        [vle_pkg::IDX_W-1:0]   visible_index,
	output logic                               last_visible,
	output logic                               overflow
);

	localparam int CNT_W  = $clog2(MAX_LINES + 1);
	localparam int ADDR_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LINES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_RD       = 6'b000010,
		S_MUL1     = 6'b000100,
		S_MUL2     = 6'b001000,
		S_EMIT_RD  = 6'b010000,
		S_EMIT_OUT = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    depth_q, depth_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    k_q, k_d;
	logic [CNT_W-1:0]    p_q, p_d;
	logic [CNT_W-1:0]    q_q, q_d;
	logic                dropped_q, dropped_d;
	logic                last_q, last_d;
	vle_pkg::line_t      new_q;
	vle_pkg::line_t      in_line;

	logic                in_acc;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	vle_pkg::line_t      mem_wdata;
	logic                re_a, re_b;
	logic [ADDR_W-1:0]   raddr_b;
	vle_pkg::line_t      line_p, line_q;

	vle_pkg::cross_ctl_t                 cross_ctl;
	logic signed [vle_pkg::OPND_W-1:0]   opa, opb;
	logic                                hidden;
	logic signed [vle_pkg::OPND_W-1:0]   mq_x, bq_x, mp_x, bp_x, mk_x, bk_x;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	assign in_line.slope     = slope;
	assign in_line.intercept = intercept;
	assign in_line.index     = vle_pkg::IDX_W'(count_q);

	// line stack
	vle_stack_mem #(
		.DEPTH  (MAX_LINES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re_a    (re_a),
		.raddr_a (p_q[ADDR_W-1:0]),
		.re_b    (re_b),
		.raddr_b (raddr_b),
		.rdata_a (line_p),
		.rdata_b (line_q)
	);

	// operand select for the two passes of the hidden test:
	// (mq-mp)*(bq-bk) + (bq-bp)*(mk-mq) > 0
	assign mq_x = {line_q.slope[vle_pkg::FIELD_W-1], line_q.slope};
	assign bq_x = {line_q.intercept[vle_pkg::FIELD_W-1], line_q.intercept};
	assign mp_x = {line_p.slope[vle_pkg::FIELD_W-1], line_p.slope};
	assign bp_x = {line_p.intercept[vle_pkg::FIELD_W-1], line_p.intercept};
	assign mk_x = {new_q.slope[vle_pkg::FIELD_W-1], new_q.slope};
	assign bk_x = {new_q.intercept[vle_pkg::FIELD_W-1], new_q.intercept};

	always_comb begin
		cross_ctl.load = (state_q == S_MUL1);
		if (state_q == S_MUL1) begin
			opa = mq_x - mp_x;
			opb = bq_x - bk_x;
		end else begin
			opa = bq_x - bp_x;
			opb = mk_x - mq_x;
		end
	end

	vle_cross_unit u_cross (
		.clk    (clk),
		.ctl    (cross_ctl),
		.opa    (opa),
		.opb    (opb),
		.hidden (hidden)
	);

	// sequencer
	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		count_d   = count_q;
		k_d       = k_q;
		p_d       = p_q;
		q_d       = q_q;
		dropped_d = dropped_q;
		last_d    = last_q;
		mem_we    = 1'b0;
		mem_waddr = depth_q[ADDR_W-1:0];
		mem_wdata = in_line;
		re_a      = 1'b0;
		re_b      = 1'b0;
		raddr_b   = q_q[ADDR_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					last_d = last_line;
					q_d    = '0;
					if (count_q < CNT_MAX) begin
						mem_we  = 1'b1;
						depth_d = depth_q + CNT_ONE;
						count_d = count_q + CNT_ONE;
						k_d     = depth_q;
						p_d     = CNT_ONE;
						if (count_q >= CNT_TWO && depth_q >= CNT_TWO) begin
							state_d = S_RD;
						end else if (last_line) begin
							state_d = S_EMIT_RD;
						end
					end else begin
						dropped_d = 1'b1;
						if (last_line) begin
							state_d = S_EMIT_RD;
						end
					end
				end
			end
			S_RD: begin
				re_a    = 1'b1;
				re_b    = 1'b1;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				state_d = S_MUL2;
			end
			S_MUL2: begin
				if (hidden) begin
					// new line replaces position p, stack cut above it
					mem_we    = 1'b1;
					mem_waddr = p_q[ADDR_W-1:0];
					mem_wdata = new_q;
					depth_d   = p_q + CNT_ONE;
					q_d       = '0;
					state_d   = last_q ? S_EMIT_RD : S_IDLE;
				end else if (q_q + CNT_ONE < p_q) begin
					q_d     = q_q + CNT_ONE;
					state_d = S_RD;
				end else if (p_q + CNT_ONE < k_q) begin
					p_d     = p_q + CNT_ONE;
					q_d     = '0;
					state_d = S_RD;
				end else begin
					q_d     = '0;
					state_d = last_q ? S_EMIT_RD : S_IDLE;
				end
			end
			S_EMIT_RD: begin
				if (depth_q == '0) begin
					depth_d   = '0;
					count_d   = '0;
					dropped_d = 1'b0;
					last_d    = 1'b0;
					state_d   = S_IDLE;
				end else begin
					re_b    = 1'b1;
					state_d = S_EMIT_OUT;
				end
			end
			S_EMIT_OUT: begin
				if (out_ready) begin
					if (q_q + CNT_ONE == depth_q) begin
						depth_d   = '0;
						count_d   = '0;
						dropped_d = 1'b0;
						last_d    = 1'b0;
						state_d   = S_IDLE;
					end else begin
						q_d     = q_q + CNT_ONE;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			depth_q   <= '0;
			count_q   <= '0;
			k_q       <= '0;
			p_q       <= '0;
			q_q       <= '0;
			dropped_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			depth_q   <= depth_d;
			count_q   <= count_d;
			k_q       <= k_d;
			p_q       <= p_d;
			q_q       <= q_d;
			dropped_q <= dropped_d;
			last_q    <= last_d;
		end
	end

	// incoming line held for the scan
	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_q <= in_line;
		end
	end

	// result word
	assign out_valid     = (state_q == S_EMIT_OUT);
	assign visible_index = line_q.index;
	assign last_visible  = (q_q + CNT_ONE == depth_q);
	assign overflow      = dropped_q;

endmodule

// ===== dv/tb_visible_lines_upper_envelope_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_visible_lines_upper_envelope_unit: self-checking bench for the envelope unit
// Feeds sets of lines through a clocked driver, predicts the visible index list
// of every set with a local stack model and checks each output word in order.
// Covers directed corner sets, random well-formed and broken sets, a deep
// convex set, an overflowing set, random idling on both sides and a long
// output hold-off that backs the unit up into its input.
// ----------------------------------------------------------------------------
module tb_visible_lines_upper_envelope_unit;

	localparam int FIELD_W      = vle_pkg::FIELD_W;
	localparam int IDX_W        = vle_pkg::IDX_W;
	localparam int MAX_LINES    = 64;
	localparam int RANDOM_ITEMS = 100;
	localparam int PHASE_ITEMS  = 25;
	localparam int HOLD_CYCLES  = 3000;
	localparam int STALL_LIMIT  = 40000;  // longest scan plus hold-off
	localparam int DRAIN_CYCLES = 200;

	typedef enum int {
		PHASE_NONE,
		PHASE_SEND,
		PHASE_RECV,
		PHASE_BOTH
	} idle_phase_t;

	// one line on its way to the input
	typedef struct {
		logic signed [FIELD_W-1:0] slope;
		logic signed [FIELD_W-1:0] intercept;
		logic                      last;
		int                        send_idle;
		int                        recv_idle;
		bit                        hold;
	} line_word_t;

	// one visible index word
	typedef struct {
		logic [IDX_W-1:0] index;
		logic             last;
		logic             ovf;
	} visible_word_t;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic signed [FIELD_W-1:0] slope         = '0;
	logic signed [FIELD_W-1:0] intercept     = '0;
	logic                      last_line     = 1'b0;
	logic                      out_valid;
	logic                      out_ready     = 1'b0;
	logic        [IDX_W-1:0]   visible_index;
	logic                      last_visible;
	logic                      overflow;

	line_word_t    pending_lines[$];
	visible_word_t expected_visible[$];

	int  total_lines    = 0;
	int  lines_accepted = 0;
	int  mismatches     = 0;
	int  stall_cycles   = 0;
	bit  watchdog_fired = 1'b0;
	int  recv_stall_pct = 0;
	bit  hold_start     = 1'b0;
	bit  hold_used      = 1'b0;
	int  hold_left      = 0;

	// generator settings applied to lines as they are queued
	int  gen_send_idle = 0;
	int  gen_recv_idle = 0;
	bit  gen_hold      = 1'b0;

	// envelope model state
	logic signed [FIELD_W-1:0] env_slope[MAX_LINES];
	logic signed [FIELD_W-1:0] env_intercept[MAX_LINES];
	logic        [IDX_W-1:0]   env_index[MAX_LINES];
	int                        env_depth   = 0;
	int                        set_count   = 0;
	bit                        set_dropped = 1'b0;

	visible_lines_upper_envelope_unit #(
		.MAX_LINES(MAX_LINES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.slope        (slope),
		.intercept    (intercept),
		.last_line    (last_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.visible_index(visible_index),
		.last_visible (last_visible),
		.overflow     (overflow)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// p is below the crossing of q and the new line k
	function automatic bit line_hidden(int q, int p, int k);
		longint mq, bq, mp, bp, mk, bk, db, dm;
		mq = env_slope[q];
		bq = env_intercept[q];
		mp = env_slope[p];
		bp = env_intercept[p];
		mk = env_slope[k];
		bk = env_intercept[k];
		db = bq - bk;
		dm = mk - mq;
		return (mq * db + bq * dm) > (mp * db + bp * dm);
	endfunction

	// push one accepted line, emit the visible list when it closes the set
	task automatic predict_line(input logic signed [FIELD_W-1:0] m,
			input logic signed [FIELD_W-1:0] b, input logic last);
		int            k;
		bit            cut;
		visible_word_t vw;
		if (set_count < MAX_LINES) begin
			k = env_depth;
			env_slope[k]     = m;
			env_intercept[k] = b;
			env_index[k]     = IDX_W'(set_count);
			env_depth        = k + 1;
			cut              = 1'b0;
			if (set_count >= 2) begin
				for (int p = 1; p < k && !cut; p++) begin
					for (int q = 0; q < p && !cut; q++) begin
						if (line_hidden(q, p, k)) begin
							env_slope[p]     = m;
							env_intercept[p] = b;
							env_index[p]     = IDX_W'(set_count);
							env_depth        = p + 1;
							cut              = 1'b1;
						end
					end
				end
			end
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			for (int i = 0; i < env_depth; i++) begin
				vw.index = env_index[i];
				vw.last  = (i == env_depth - 1);
				vw.ovf   = set_dropped;
				expected_visible.push_back(vw);
			end
			env_depth   = 0;
			set_count   = 0;
			set_dropped = 1'b0;
		end
	endtask

	// ---------------- stimulus generation ----------------

	task automatic add_line(input int m, input int b, input bit last);
		line_word_t lw;
		lw.slope     = FIELD_W'(m);
		lw.intercept = FIELD_W'(b);
		lw.last      = last;
		lw.send_idle = gen_send_idle;
		lw.recv_idle = gen_recv_idle;
		lw.hold      = gen_hold;
		gen_hold     = 1'b0;
		pending_lines.push_back(lw);
	endtask

	task automatic set_phase(input idle_phase_t ph);
		case (ph)
			PHASE_NONE: begin
				gen_send_idle = 0;
				gen_recv_idle = 0;
			end
			PHASE_SEND: begin
				gen_send_idle = 63;
				gen_recv_idle = 0;
			end
			PHASE_RECV: begin
				gen_send_idle = 0;
				gen_recv_idle = 63;
			end
			default: begin
				gen_send_idle = 7;
				gen_recv_idle = 7;
			end
		endcase
	endtask

	// strictly increasing slopes; narrow keeps values close so lines interact
	task automatic add_increasing_set(input int n, input bit narrow);
		int s, step_max, b;
		if (narrow) begin
			step_max = 4;
			s        = $urandom_range(0, 400) - 200;
		end else begin
			step_max = 65535 / n;
			s        = $urandom_range(0, step_max - 1) - 32768;
		end
		for (int i = 0; i < n; i++) begin
			if (narrow)
				b = $urandom_range(0, 255) - 128;
			else
				b = $urandom_range(0, 65535) - 32768;
			add_line(s, b, i == n - 1);
			s += $urandom_range(1, step_max);
		end
	endtask

	// tangents of a parabola: nearly all lines stay visible
	task automatic add_convex_set(input int n, input int a0, input int jitter);
		int a;
		for (int i = 0; i < n; i++) begin
			a = a0 + i;
			add_line(2 * a, -(a * a) + $urandom_range(0, jitter), i == n - 1);
		end
	endtask

	// unordered, repeated and falling slopes
	task automatic add_broken_set(input int n);
		for (int i = 0; i < n; i++)
			add_line($urandom_range(0, 16) - 8, $urandom_range(0, 64) - 32, i == n - 1);
	endtask

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin : drive_proc
		line_word_t lw;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			slope     <= '0;
			intercept <= '0;
			last_line <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_lines.size() != 0 &&
					$urandom_range(0, 99) >= pending_lines[0].send_idle) begin
				lw = pending_lines.pop_front();
				in_valid       <= 1'b1;
				slope          <= lw.slope;
				intercept      <= lw.intercept;
				last_line      <= lw.last;
				recv_stall_pct <= lw.recv_idle;
				if (lw.hold)
					hold_start <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- receiver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_start && !hold_used) begin
			// long hold-off so the unit backs up into its input
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// ---------------- monitor and watchdog ----------------
	always @(posedge clk) begin : check_proc
		visible_word_t vw;
		bit            moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready) begin
				predict_line(slope, intercept, last_line);
				lines_accepted++;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (expected_visible.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word index=%0d last=%0b ovf=%0b",
						$time, visible_index, last_visible, overflow);
				end else begin
					vw = expected_visible.pop_front();
					if (visible_index !== vw.index || last_visible !== vw.last ||
							overflow !== vw.ovf) begin
						mismatches++;
						$display("%0t: expected idx=%0d last=%0b ovf=%0b, %s",
							$time, vw.index, vw.last, vw.ovf, "got");
						$display("%0t:      got idx=%0d last=%0b ovf=%0b",
							$time, visible_index, last_visible, overflow);
					end
				end
			end
			if (moved) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT && !watchdog_fired) begin
					watchdog_fired = 1'b1;
					$display("%0t: watchdog, no word moved for %0d cycles", $time,
						STALL_LIMIT);
				end
			end
		end
	end

	// ---------------- sequence ----------------
	initial begin
		int random_items, pick, n;
		bit overflow_done;

		// directed corner sets, no idling
		set_phase(PHASE_NONE);
		add_line(-32768, -32768, 1'b1);                 // lone line
		add_line(-32768, 32767, 1'b0);                  // two lines, extremes
		add_line(32767, -32768, 1'b1);
		add_line(-1, 0, 1'b0);                          // middle line hidden
		add_line(0, -10, 1'b0);
		add_line(1, 0, 1'b1);
		add_line(-1, 0, 1'b0);                          // middle line visible
		add_line(0, 10, 1'b0);
		add_line(1, 0, 1'b1);
		add_line(-1, 5, 1'b0);                          // three lines through one point
		add_line(0, 5, 1'b0);
		add_line(1, 5, 1'b1);
		add_line(7, 1, 1'b0);                           // equal slopes
		add_line(7, 2, 1'b0);
		add_line(7, 3, 1'b1);
		add_line(100, 0, 1'b0);                         // falling slopes
		add_line(0, 50, 1'b0);
		add_line(-100, 0, 1'b0);
		add_line(-200, -300, 1'b1);
		add_line(-32768, 32767, 1'b0);                  // widest cross products
		add_line(-1, -32768, 1'b0);
		add_line(32767, 32767, 1'b1);

		// random sets, idling phases rotate every 25 items
		random_items  = 0;
		overflow_done = 1'b0;
		gen_hold      = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			set_phase(idle_phase_t'((random_items / PHASE_ITEMS) % 4));
			if (!overflow_done && random_items >= 50) begin
				// past capacity: the closing line itself is dropped
				add_increasing_set(66, 1'b1);
				overflow_done = 1'b1;
			end
			pick = $urandom_range(0, 19);
			if (pick < 8) begin
				n = $urandom_range(1, 10);
				add_increasing_set(n, 1'b0);
			end else if (pick < 13) begin
				n = $urandom_range(2, 12);
				add_increasing_set(n, 1'b1);
			end else if (pick < 16) begin
				n = $urandom_range(3, 12);
				add_convex_set(n, $urandom_range(0, 180) - 100, $urandom_range(0, 3));
			end else begin
				n = $urandom_range(2, 8);
				add_broken_set(n);
			end
			random_items += n;
		end

		// full capacity with every line visible
		set_phase(PHASE_BOTH);
		add_convex_set(MAX_LINES, -32, 0);

		total_lines = pending_lines.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!watchdog_fired &&
				!(lines_accepted == total_lines && expected_visible.size() == 0))
			@(negedge clk);
		if (!watchdog_fired)
			repeat (DRAIN_CYCLES) @(negedge clk);

		if (watchdog_fired || mismatches != 0 || expected_visible.size() != 0) begin
			$display("visible_lines_upper_envelope_unit test failed");
		end else begin
			$display("visible_lines_upper_envelope_unit test passed");
		end
		$finish;
	end

endmodule
